@@ design/led_cbf_pkg.sv @@
// ----------------------------------------------------------------------------
// led_cbf_pkg: shared types and constants of the blink crossfader
// Holds the sequencer states, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package led_cbf_pkg;

    // Q0.16 position, one extra bit so that full scale (1.0) fits
    localparam int POS_BITS = 16;
    localparam logic [POS_BITS:0] POS_ONE = 17'h10000;

    // period and color registers are fixed at 32 bits, half period fits 31
    localparam int REG_BITS  = 32;
    localparam int HALF_BITS = 31;

    // register indexes on the configuration port (byte address = 4 * index)
    localparam logic [1:0] REG_COLOR_A = 2'd0;
    localparam logic [1:0] REG_COLOR_B = 2'd1;
    localparam logic [1:0] REG_PERIOD  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ELAPSED,
        ST_SELECT,
        ST_DIVIDE,
        ST_BLEND,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

@@ design/led_color_blink_fader_top.sv @@
// ----------------------------------------------------------------------------
// led_color_blink_fader_top: two-color blink crossfader
// Takes a time stamp per request and returns one interpolated RGBA color.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one time stamp per request in s_tdata.
//   m_ channel: red, green, blue, alpha and transparency in m_tdata.
//   APB port: color_a at 0x0, color_b at 0x4, period_ticks at 0x8.
//   Write the registers only while no request is in flight.
// Sequence:
//   After acceptance a request passes cycle bookkeeping and phase select, the
//   bit-serial divider that forms the Q0.16 position (16 quotient bits, then
//   the handoff; skipped when the position saturates), the one shared blend
//   multiplier, one channel at a time, then the output register load that
//   raises m_tvalid.
//   s_tready is high only in the idle state, so a new request is taken only
//   after the last one has loaded its result into the output register.
// Reset:
//   aresetn low clears the cycle start, so the next request starts a cycle,
//   and loads the register reset colors and period.
// Stall:
//   A result holds in the output register until m_tready; the next request is
//   accepted meanwhile and its result waits until the register is free.
// ----------------------------------------------------------------------------
module led_color_blink_fader_top #(
    parameter int TIME_BITS    = 48,
    parameter int CHANNEL_BITS = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // fields from bit 0 up: time_now
    input  logic [((TIME_BITS + 7) / 8) * 8 - 1:0]        s_tdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // fields from bit 0 up: red, green, blue, alpha, transparency
    output logic [((5 * CHANNEL_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int OUT_BITS = ((5 * CHANNEL_BITS + 7) / 8) * 8;
    localparam int EW       = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int RB       = led_cbf_pkg::REG_BITS;

    function automatic logic [CHANNEL_BITS-1:0] chan_of(input logic [RB-1:0] packed_c,
                                                        input logic [1:0] k);
        logic [5:0]  sh;
        logic [63:0] w;
        sh = 6'(CHANNEL_BITS * (3 - int'(k)));
        w  = {32'b0, packed_c} >> sh;
        return w[CHANNEL_BITS-1:0];
    endfunction

    led_cbf_pkg::state_t state_reg, state_next;

    logic [RB-1:0]            color_a_reg, color_b_reg, period_reg;
    logic [TIME_BITS-1:0]     now_reg, now_next;
    logic [TIME_BITS-1:0]     cycle_start_reg, cycle_start_next;
    logic [EW-1:0]            elapsed_reg, elapsed_next;
    logic [RB-1:0]            from_reg, from_next, to_reg, to_next;
    logic [led_cbf_pkg::POS_BITS:0] pos_reg, pos_next;
    logic [1:0]               chan_cnt_reg, chan_cnt_next;
    logic [CHANNEL_BITS-1:0]  chan_reg [4];
    logic [OUT_BITS-1:0]      out_data_reg, out_data_next;
    logic                     m_valid_reg, m_valid_next;

    logic                     cfg_write;
    logic                     in_accept;
    logic                     div_start;
    logic                     load_out;
    logic                     chan_load;
    logic [RB-1:0]            period_eff;
    logic [led_cbf_pkg::HALF_BITS-1:0] half;
    logic [TIME_BITS-1:0]     start_eff;
    logic [TIME_BITS-1:0]     elapsed_raw;
    logic                     first_half;
    logic [EW-1:0]            phase_elapsed;
    logic                     saturated;
    logic [led_cbf_pkg::POS_BITS-1:0] quotient;
    led_cbf_pkg::div_status_t div_status;
    logic [CHANNEL_BITS-1:0]  mix_chan;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_a_reg <= 32'hFF0000FF;
            color_b_reg <= 32'h000000FF;
            period_reg  <= 32'd1000000;
        end else if (cfg_write) begin
            case (paddr[3:2])
                led_cbf_pkg::REG_COLOR_A: color_a_reg <= pwdata;
                led_cbf_pkg::REG_COLOR_B: color_b_reg <= pwdata;
                led_cbf_pkg::REG_PERIOD:  period_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            led_cbf_pkg::REG_COLOR_A: prdata = color_a_reg;
            led_cbf_pkg::REG_COLOR_B: prdata = color_b_reg;
            led_cbf_pkg::REG_PERIOD:  prdata = period_reg;
            default:                  prdata = '0;
        endcase
    end

    // ---------------- shared units ----------------
    led_cbf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (phase_elapsed[RB-1:0]),
        .divisor  (half),
        .quotient (quotient),
        .status   (div_status)
    );

    led_cbf_mix #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_mix (
        .from_chan (chan_of(from_reg, chan_cnt_reg)),
        .to_chan   (chan_of(to_reg, chan_cnt_reg)),
        .pos       (pos_reg),
        .mix_chan  (mix_chan)
    );

    // ---------------- sequencer: next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            led_cbf_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = led_cbf_pkg::ST_ELAPSED;
                end
            end
            led_cbf_pkg::ST_ELAPSED: state_next = led_cbf_pkg::ST_SELECT;
            led_cbf_pkg::ST_SELECT: begin
                state_next = saturated ? led_cbf_pkg::ST_BLEND : led_cbf_pkg::ST_DIVIDE;
            end
            led_cbf_pkg::ST_DIVIDE: begin
                if (div_status.done) begin
                    state_next = led_cbf_pkg::ST_BLEND;
                end
            end
            led_cbf_pkg::ST_BLEND: begin
                if (chan_cnt_reg == 2'd3) begin
                    state_next = led_cbf_pkg::ST_DONE;
                end
            end
            led_cbf_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = led_cbf_pkg::ST_IDLE;
                end
            end
            default: state_next = led_cbf_pkg::ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        chan_load = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            led_cbf_pkg::ST_IDLE:   s_tready  = 1'b1;
            led_cbf_pkg::ST_SELECT: div_start = !saturated;
            led_cbf_pkg::ST_BLEND:  chan_load = 1'b1;
            led_cbf_pkg::ST_DONE:   load_out  = !m_valid_reg || m_tready;
            default: ;
        endcase
    end

    assign in_accept = s_tvalid && s_tready;

    // ---------------- datapath ----------------
    always_comb begin
        period_eff  = (period_reg < RB'(2)) ? RB'(2) : period_reg;
        half        = period_eff[RB-1:1];
        // restart the cycle when not started or when time ran backward
        start_eff   = (cycle_start_reg == '0 || cycle_start_reg > now_reg)
                      ? now_reg : cycle_start_reg;
        elapsed_raw = now_reg - start_eff;

        first_half    = elapsed_reg < EW'(half);
        phase_elapsed = first_half ? elapsed_reg : elapsed_reg - EW'(half);
        saturated     = phase_elapsed >= EW'(half);

        now_next         = now_reg;
        cycle_start_next = cycle_start_reg;
        elapsed_next     = elapsed_reg;
        from_next        = from_reg;
        to_next          = to_reg;
        pos_next         = pos_reg;
        chan_cnt_next    = chan_cnt_reg;
        out_data_next    = out_data_reg;
        m_valid_next     = m_valid_reg && !m_tready;

        if (in_accept) begin
            now_next = s_tdata[TIME_BITS-1:0];
        end
        if (state_reg == led_cbf_pkg::ST_ELAPSED) begin
            elapsed_next     = EW'(elapsed_raw);
            cycle_start_next = (EW'(elapsed_raw) >= EW'(period_eff)) ? now_reg : start_eff;
        end
        if (state_reg == led_cbf_pkg::ST_SELECT) begin
            from_next     = first_half ? color_a_reg : color_b_reg;
            to_next       = first_half ? color_b_reg : color_a_reg;
            pos_next      = led_cbf_pkg::POS_ONE;
            chan_cnt_next = '0;
        end
        if (state_reg == led_cbf_pkg::ST_DIVIDE && div_status.done) begin
            pos_next = {1'b0, quotient};
        end
        if (chan_load) begin
            chan_cnt_next = chan_cnt_reg + 1'b1;
        end
        if (load_out) begin
            out_data_next = '0;
            out_data_next[0*CHANNEL_BITS +: CHANNEL_BITS] = chan_reg[0];
            out_data_next[1*CHANNEL_BITS +: CHANNEL_BITS] = chan_reg[1];
            out_data_next[2*CHANNEL_BITS +: CHANNEL_BITS] = chan_reg[2];
            out_data_next[3*CHANNEL_BITS +: CHANNEL_BITS] = chan_reg[3];
            out_data_next[4*CHANNEL_BITS +: CHANNEL_BITS] = ~chan_reg[3];
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= led_cbf_pkg::ST_IDLE;
            cycle_start_reg <= '0;
            chan_cnt_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cycle_start_reg <= cycle_start_next;
            chan_cnt_reg    <= chan_cnt_next;
            m_valid_reg     <= m_valid_next;
        end
        now_reg      <= now_next;
        elapsed_reg  <= elapsed_next;
        from_reg     <= from_next;
        to_reg       <= to_next;
        pos_reg      <= pos_next;
        out_data_reg <= out_data_next;
        if (chan_load) begin
            chan_reg[chan_cnt_reg] <= mix_chan;
        end
    end

    assign m_tdata  = out_data_reg;
    assign m_tvalid = m_valid_reg;

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == led_cbf_pkg::ST_BLEND) |-> (pos_reg <= led_cbf_pkg::POS_ONE))
        else $error("blend position above full scale");

    a_start_not_future: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == led_cbf_pkg::ST_SELECT) |-> (cycle_start_reg <= now_reg))
        else $error("cycle start lies after the time stamp");

    a_valid_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == led_cbf_pkg::ST_DONE))
        else $error("result shown outside the done state");

    a_div_idle_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.busy |-> (state_reg == led_cbf_pkg::ST_DIVIDE))
        else $error("divider busy outside the divide state");
`endif

endmodule

@@ design/led_cbf_div.sv @@
// ----------------------------------------------------------------------------
// led_cbf_div: restoring divider for the crossfade position
// Computes floor(dividend * 2^16 / divisor) one quotient bit per cycle,
// for a dividend below the divisor.
// ----------------------------------------------------------------------------
module led_cbf_div (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [led_cbf_pkg::REG_BITS-1:0]      dividend,
    input  logic [led_cbf_pkg::HALF_BITS-1:0]     divisor,
    output logic [led_cbf_pkg::POS_BITS-1:0]      quotient,
    output led_cbf_pkg::div_status_t              status
);

    localparam int CNT_BITS = $clog2(led_cbf_pkg::POS_BITS);

    logic [led_cbf_pkg::REG_BITS-1:0]  rem_reg, rem_next;
    logic [led_cbf_pkg::POS_BITS-1:0]  quo_reg, quo_next;
    logic [led_cbf_pkg::HALF_BITS-1:0] dsr_reg, dsr_next;
    logic [CNT_BITS-1:0]               cnt_reg, cnt_next;
    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [led_cbf_pkg::REG_BITS:0]    trial;
    logic                              fits;

    always_comb begin
        trial = {rem_reg, 1'b0};
        fits  = trial >= {2'b00, dsr_reg};
    end

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = dividend;
            dsr_next  = divisor;
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // subtract when the shifted remainder covers the divisor
            if (fits) begin
                rem_next = led_cbf_pkg::REG_BITS'(trial - {2'b00, dsr_reg});
            end else begin
                rem_next = trial[led_cbf_pkg::REG_BITS-1:0];
            end
            quo_next = {quo_reg[led_cbf_pkg::POS_BITS-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_BITS'(led_cbf_pkg::POS_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

@@ design/led_cbf_mix.sv @@
// ----------------------------------------------------------------------------
// led_cbf_mix: one-channel linear blend
// Gives round(from + (to - from) * pos / 2^16), ties going up.
// ----------------------------------------------------------------------------
module led_cbf_mix #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic [CHANNEL_BITS-1:0]           from_chan,
    input  logic [CHANNEL_BITS-1:0]           to_chan,
    input  logic [led_cbf_pkg::POS_BITS:0]    pos,
    output logic [CHANNEL_BITS-1:0]           mix_chan
);

    localparam int PROD_BITS = CHANNEL_BITS + led_cbf_pkg::POS_BITS + 3;

    logic signed [CHANNEL_BITS:0]  diff;
    logic signed [PROD_BITS-1:0]   prod;
    logic signed [PROD_BITS-1:0]   rounded;
    logic signed [PROD_BITS-1:0]   step;

    always_comb begin
        diff    = $signed({1'b0, to_chan}) - $signed({1'b0, from_chan});
        prod    = diff * $signed({1'b0, pos});
        rounded = prod + $signed(PROD_BITS'(1) <<< (led_cbf_pkg::POS_BITS - 1));
        step    = rounded >>> led_cbf_pkg::POS_BITS;
        // result stays within the channel range, so wrap is exact
        mix_chan = from_chan + step[CHANNEL_BITS-1:0];
    end

endmodule
